>>> hw/rtl/hftd_pkg.sv
// Shared types and constants of the code-tree walk decoder.
`timescale 1ns / 1ps

package hftd_pkg;

	localparam int NODE_COUNT_DEF   = 512;
	localparam int MAX_CODE_LEN_DEF = 32;

	localparam int SYM_W      = 8;
	localparam int CODE_W     = 32;
	localparam int LEN_W      = 6;
	localparam int BYTE_W     = 8;
	localparam int SKIP_W     = 3;
	localparam int REM_W      = 4;
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 8;

	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BADPATH = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic              command;
		logic [SYM_W-1:0]  symbol_in;
		logic [CODE_W-1:0] code_bits;
		logic [LEN_W-1:0]  code_length;
		logic [BYTE_W-1:0] coded_byte;
		logic [SKIP_W-1:0] ignored_low_bits;
	} item_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol_out;
		status_t          status;
		logic             last;
	} res_t;

endpackage

>>> hw/rtl/hftd_node_ram.sv
// Node table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module hftd_node_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9,
	parameter int DW    = 26
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> hw/rtl/hftd_out_reg.sv
// Result register on the master side.
`timescale 1ns / 1ps

module hftd_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hftd_pkg::res_t push_res,
	output logic          out_free,
	output logic          m_valid,
	input  logic          m_ready,
	output hftd_pkg::res_t m_res
);

	import hftd_pkg::*;

	logic valid_q;
	res_t res_q;

	assign out_free = !valid_q || m_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else if (push && out_free) begin
			valid_q <= 1'b1;
			res_q   <= push_res;
		end else if (m_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign m_valid = valid_q;
	assign m_res   = res_q;

endmodule

>>> hw/rtl/hftd_walk_ctrl.sv
// Tree walk sequencer: code loads and byte decodes over the node table.
`timescale 1ns / 1ps

module hftd_walk_ctrl #(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 32,
	parameter int IW           = 9,
	parameter int RW           = 26
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	output logic           s_ready,
	input  hftd_pkg::item_t s_item,
	output logic           rd_en,
	output logic [IW-1:0]  rd_addr,
	input  logic [RW-1:0]  rd_row,
	output logic           wr_en,
	output logic [IW-1:0]  wr_addr,
	output logic [RW-1:0]  wr_row,
	output logic           push,
	output hftd_pkg::res_t push_res,
	input  logic           out_free
);

	import hftd_pkg::*;

	localparam int CW = $clog2(NODE_COUNT + 1);
	localparam int LW = $clog2(MAX_CODE_LEN + 1);

	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DEC} state_t;

	state_t            state_q, state_d;
	logic [IW-1:0]     walk_q, walk_d;
	logic              chk_q, chk_d;
	logic [IW-1:0]     ld_node_q, ld_node_d;
	logic              fresh_q, fresh_d;
	logic [RW-1:0]     root_q, root_d;
	logic [CW-1:0]     nodes_q, nodes_d;
	logic [SYM_W-1:0]  sym_q, sym_d;
	logic [CODE_W-1:0] code_q, code_d;
	logic [LW-1:0]     cnt_q, cnt_d;
	logic              lz_q, lz_d;
	logic [BYTE_W-1:0] byte_q, byte_d;
	logic [REM_W-1:0]  rem_q, rem_d;
	logic              hold_v_q, hold_v_d;
	res_t              hold_q, hold_d;

	logic [RW-1:0]     row_ld, row_dc, new_row;
	logic [31:0]       ld_pos;
	logic              ld_bit, dc_bit, leaf_hit, emit_ok, full;
	logic [IW-1:0]     ld_child, dc_child, root_child, new_idx;
	res_t              res_new;

	always_comb begin
		state_d   = state_q;
		walk_d    = walk_q;
		chk_d     = chk_q;
		ld_node_d = ld_node_q;
		fresh_d   = fresh_q;
		nodes_d   = nodes_q;
		sym_d     = sym_q;
		code_d    = code_q;
		cnt_d     = cnt_q;
		lz_d      = lz_q;
		byte_d    = byte_q;
		rem_d     = rem_q;
		hold_v_d  = hold_v_q;
		hold_d    = hold_q;
		rd_en     = 1'b0;
		rd_addr   = walk_q;
		wr_en     = 1'b0;
		wr_addr   = ld_node_q;
		push      = 1'b0;
		push_res  = hold_q;
		res_new   = '0;
		s_ready   = (state_q == S_IDLE);

		// current row of the load walk: fresh nodes are all zero until written
		row_ld = fresh_q ? '0 : ((ld_node_q == '0) ? root_q : rd_row);
		row_dc = (walk_q == '0) ? root_q : rd_row;

		ld_pos     = 32'(cnt_q) - 32'd1;
		ld_bit     = (ld_pos < 32'd32) ? code_q[ld_pos[4:0]] : 1'b0;
		ld_child   = ld_bit ? row_ld[2*IW-1:IW] : row_ld[IW-1:0];
		dc_bit     = byte_q[BYTE_W-1];
		dc_child   = dc_bit ? row_dc[2*IW-1:IW] : row_dc[IW-1:0];
		root_child = dc_bit ? root_q[2*IW-1:IW] : root_q[IW-1:0];
		leaf_hit   = chk_q && (row_dc[RW-1:2*IW] != '0);
		emit_ok    = !hold_v_q || out_free;
		full       = (nodes_q == CW'(NODE_COUNT));
		new_idx    = nodes_q[IW-1:0];

		new_row = row_ld;
		if (ld_bit) begin
			new_row[2*IW-1:IW] = new_idx;
		end else begin
			new_row[IW-1:0] = new_idx;
		end
		wr_row = new_row;

		unique case (state_q)
			S_IDLE: begin
				if (s_valid) begin
					sym_d  = s_item.symbol_in;
					code_d = s_item.code_bits;
					byte_d = s_item.coded_byte;
					rem_d  = REM_W'(8) - REM_W'(s_item.ignored_low_bits);
					if (s_item.command == CMD_LOAD) begin
						ld_node_d = '0;
						fresh_d   = 1'b0;
						lz_d      = (s_item.code_length == '0);
						cnt_d     = (s_item.code_length > LEN_W'(MAX_CODE_LEN))
							? LW'(MAX_CODE_LEN) : LW'(s_item.code_length);
						state_d   = S_LOAD;
					end else begin
						// row of a parked non-root position comes back next cycle
						rd_en   = 1'b1;
						rd_addr = walk_q;
						chk_d   = 1'b0;
						state_d = S_DEC;
					end
				end
			end
			S_LOAD: begin
				if (cnt_q == '0) begin
					if (out_free) begin
						push     = 1'b1;
						push_res = '{symbol_out: '0, status: ST_OK, last: 1'b1};
						if (!lz_q) begin
							wr_en  = 1'b1;
							wr_row = {sym_q, row_ld[2*IW-1:0]};
						end
						state_d = S_IDLE;
					end
				end else if (ld_child != '0) begin
					rd_en     = 1'b1;
					rd_addr   = ld_child;
					ld_node_d = ld_child;
					fresh_d   = 1'b0;
					cnt_d     = cnt_q - LW'(1);
				end else if (full) begin
					if (out_free) begin
						// flush the current row so a fresh node lands as zeros
						wr_en    = 1'b1;
						wr_row   = row_ld;
						push     = 1'b1;
						push_res = '{symbol_out: '0, status: ST_FULL, last: 1'b1};
						state_d  = S_IDLE;
					end
				end else begin
					wr_en     = 1'b1;
					nodes_d   = nodes_q + CW'(1);
					ld_node_d = new_idx;
					fresh_d   = 1'b1;
					cnt_d     = cnt_q - LW'(1);
				end
			end
			S_DEC: begin
				if (leaf_hit) begin
					res_new = '{symbol_out: row_dc[RW-1:2*IW], status: ST_OK, last: 1'b0};
					if (emit_ok) begin
						push     = hold_v_q;
						hold_v_d = 1'b1;
						hold_d   = res_new;
						walk_d   = '0;
						chk_d    = 1'b0;
						// next bit may start from the root in the same cycle
						if (rem_q != '0 && root_child != '0) begin
							rd_en   = 1'b1;
							rd_addr = root_child;
							walk_d  = root_child;
							chk_d   = 1'b1;
							rem_d   = rem_q - REM_W'(1);
							byte_d  = {byte_q[BYTE_W-2:0], 1'b0};
						end
					end
				end else if (rem_q != '0) begin
					if (dc_child != '0) begin
						rd_en   = 1'b1;
						rd_addr = dc_child;
						walk_d  = dc_child;
						chk_d   = 1'b1;
						rem_d   = rem_q - REM_W'(1);
						byte_d  = {byte_q[BYTE_W-2:0], 1'b0};
					end else begin
						res_new = '{symbol_out: '0, status: ST_BADPATH, last: 1'b0};
						if (emit_ok) begin
							push     = hold_v_q;
							hold_v_d = 1'b1;
							hold_d   = res_new;
							walk_d   = '0;
							chk_d    = 1'b0;
							rem_d    = rem_q - REM_W'(1);
							byte_d   = {byte_q[BYTE_W-2:0], 1'b0};
						end
					end
				end else begin
					chk_d = 1'b0;
					if (!hold_v_q) begin
						state_d = S_IDLE;
					end else if (out_free) begin
						push          = 1'b1;
						push_res.last = 1'b1;
						hold_v_d      = 1'b0;
						state_d       = S_IDLE;
					end
				end
				if (push && hold_v_q && state_d != S_IDLE) begin
					push_res.last = 1'b0;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		root_d = root_q;
		if (wr_en && wr_addr == '0) begin
			root_d = wr_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			walk_q    <= '0;
			chk_q     <= 1'b0;
			ld_node_q <= '0;
			fresh_q   <= 1'b0;
			root_q    <= '0;
			nodes_q   <= CW'(1);
			sym_q     <= '0;
			code_q    <= '0;
			cnt_q     <= '0;
			lz_q      <= 1'b0;
			byte_q    <= '0;
			rem_q     <= '0;
			hold_v_q  <= 1'b0;
			hold_q    <= '0;
		end else begin
			state_q   <= state_d;
			walk_q    <= walk_d;
			chk_q     <= chk_d;
			ld_node_q <= ld_node_d;
			fresh_q   <= fresh_d;
			root_q    <= root_d;
			nodes_q   <= nodes_d;
			sym_q     <= sym_d;
			code_q    <= code_d;
			cnt_q     <= cnt_d;
			lz_q      <= lz_d;
			byte_q    <= byte_d;
			rem_q     <= rem_d;
			hold_v_q  <= hold_v_d;
			hold_q    <= hold_d;
		end
	end

endmodule

>>> hw/rtl/huffman_tree_decoder.sv
// Top level of the code-tree walk decoder.
`timescale 1ns / 1ps
// Load request: walks min(code_length, MAX_CODE_LEN) code bits, one result.
// Decode request: walks the top (8 - ignored_low_bits) bits of coded_byte.
// The rate is set by the node RAM read loop: each child read feeds the next.
// Reset is asynchronous; the table needs no clearing pass, a fill counter
//   marks allocated nodes and the root row lives in flops.

module huffman_tree_decoder #(
	parameter int NODE_COUNT   = hftd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = hftd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// symbol_in[7:0], code_bits[39:8], code_length[45:40], coded_byte[53:46],
	// ignored_low_bits[56:54], zero fill [63:57]
	input  logic [hftd_pkg::S_TDATA_W-1:0] s_tdata,
	// command (0 load, 1 decode)
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// symbol_out[7:0]
	output logic [hftd_pkg::M_TDATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [1:0]                     m_tuser,
	// last result of the request
	output logic                           m_tlast
);

	import hftd_pkg::*;

	// node row: leaf symbol over right child over left child
	localparam int IW = $clog2(NODE_COUNT);
	localparam int RW = 2 * IW + SYM_W;

	item_t         item;
	logic          rd_en, wr_en, push, out_free;
	logic [IW-1:0] rd_addr, wr_addr;
	logic [RW-1:0] rd_row, wr_row;
	res_t          push_res, m_res;

	assign item.command          = s_tuser;
	assign item.symbol_in        = s_tdata[7:0];
	assign item.code_bits        = s_tdata[39:8];
	assign item.code_length      = s_tdata[45:40];
	assign item.coded_byte       = s_tdata[53:46];
	assign item.ignored_low_bits = s_tdata[56:54];

	// sequencer owns the walk; it talks to the table through one read and one write
	hftd_walk_ctrl #(
		.NODE_COUNT  (NODE_COUNT),
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.IW          (IW),
		.RW          (RW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_tvalid),
		.s_ready (s_tready),
		.s_item  (item),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_row  (rd_row),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_row  (wr_row),
		.push    (push),
		.push_res(push_res),
		.out_free(out_free)
	);

	hftd_node_ram #(
		.DEPTH(NODE_COUNT),
		.AW   (IW),
		.DW   (RW)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_row),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_row)
	);

	// results leave through a register so the walk runs while one waits
	hftd_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_res(push_res),
		.out_free(out_free),
		.m_valid (m_tvalid),
		.m_ready (m_tready),
		.m_res   (m_res)
	);

	assign m_tdata = m_res.symbol_out;
	assign m_tuser = m_res.status;
	assign m_tlast = m_res.last;

endmodule

>>> hw/rtl/hftd_checker.sv
// Port-level checks of the decoder, bound to the top level.
`timescale 1ns / 1ps

module hftd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [1:0] m_tuser,
	input logic       m_tlast
);

	import hftd_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in work");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_BADPATH || m_tuser == ST_FULL))
		else $error("undefined status code");

	a_status_no_sym: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_OK |-> m_tdata == '0)
		else $error("symbol on error result");

	a_full_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> m_tlast)
		else $error("table-full result not last");

endmodule

bind huffman_tree_decoder hftd_checker u_hftd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser),
	.m_tlast (m_tlast)
);

>>> tb/hftd_checker.sv
// Channel monitor with a tree-walk predictor and in-order result comparison.
`timescale 1ns / 1ps

module hftd_scoreboard (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [hftd_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [hftd_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [1:0]                     m_tuser,
	input  logic                           m_tlast,
	output int                             errors,
	output int                             pending,
	output logic                           table_full,
	output int                             results_seen,
	output int                             bad_paths,
	output int                             full_loads
);

	import hftd_pkg::*;

	localparam int NODES      = NODE_COUNT_DEF;
	localparam int MAX_LEN    = MAX_CODE_LEN_DEF;
	localparam int IDX_W      = $clog2(NODES);
	localparam int CODE_LSB   = SYM_W;
	localparam int LEN_LSB    = CODE_LSB + CODE_W;
	localparam int BYTE_LSB   = LEN_LSB + LEN_W;
	localparam int SKIP_LSB   = BYTE_LSB + BYTE_W;

	// predicted tree; index 0 as a child means absent, leaf 0 means internal
	logic [IDX_W-1:0] left_tbl  [NODES];
	logic [IDX_W-1:0] right_tbl [NODES];
	logic [SYM_W-1:0] leaf_tbl  [NODES];
	int unsigned      nodes_used;
	logic [IDX_W-1:0] walk_node;

	res_t awaited_results[$];
	int   fail_tally;
	int   result_tally;
	int   bad_path_tally;
	int   full_tally;

	assign errors       = fail_tally;
	assign results_seen = result_tally;
	assign bad_paths    = bad_path_tally;
	assign full_loads   = full_tally;

	function automatic status_t insert_code(logic [SYM_W-1:0] sym, logic [CODE_W-1:0] code,
			logic [LEN_W-1:0] len);
		int               depth;
		logic [IDX_W-1:0] node;
		logic [IDX_W-1:0] nxt;
		logic             code_bit;
		depth = (int'(len) > MAX_LEN) ? MAX_LEN : int'(len);
		node  = '0;
		for (int k = depth - 1; k >= 0; k--) begin
			code_bit = (k < CODE_W) ? code[k] : 1'b0;
			nxt = code_bit ? right_tbl[node] : left_tbl[node];
			if (nxt == '0) begin
				// partial path stays when the table runs out
				if (nodes_used >= NODES)
					return ST_FULL;
				nxt = IDX_W'(nodes_used);
				nodes_used++;
				left_tbl[nxt]  = '0;
				right_tbl[nxt] = '0;
				leaf_tbl[nxt]  = '0;
				if (code_bit)
					right_tbl[node] = nxt;
				else
					left_tbl[node] = nxt;
			end
			node = nxt;
		end
		if (depth > 0)
			leaf_tbl[node] = sym;
		return ST_OK;
	endfunction

	function automatic void decode_byte(logic [BYTE_W-1:0] coded, logic [SKIP_W-1:0] skip);
		logic [IDX_W-1:0] nxt;
		res_t             r;
		int               produced;
		produced = 0;
		for (int i = BYTE_W - 1; i >= int'(skip); i--) begin
			nxt = coded[i] ? right_tbl[walk_node] : left_tbl[walk_node];
			r.last = 1'b0;
			if (nxt == '0) begin
				r.symbol_out = '0;
				r.status     = ST_BADPATH;
				awaited_results.push_back(r);
				produced++;
				walk_node = '0;
			end else begin
				walk_node = nxt;
				// first leaf on the way ends the code, children or not
				if (leaf_tbl[nxt] != '0) begin
					r.symbol_out = leaf_tbl[nxt];
					r.status     = ST_OK;
					awaited_results.push_back(r);
					produced++;
					walk_node = '0;
				end
			end
		end
		if (produced > 0)
			awaited_results[awaited_results.size() - 1].last = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t r;
		if (!arst_n) begin
			for (int n = 0; n < NODES; n++) begin
				left_tbl[n]  = '0;
				right_tbl[n] = '0;
				leaf_tbl[n]  = '0;
			end
			nodes_used = 1;
			walk_node  = '0;
			awaited_results.delete();
			fail_tally     = 0;
			result_tally   = 0;
			bad_path_tally = 0;
			full_tally     = 0;
			pending    <= 0;
			table_full <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				result_tally++;
				if (awaited_results.size() == 0) begin
					fail_tally++;
					$display("%0t: unexpected result: expected none, got sym %h st %0d last %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					r = awaited_results.pop_front();
					if (r.status == ST_BADPATH)
						bad_path_tally++;
					if (r.status == ST_FULL)
						full_tally++;
					if (m_tdata !== r.symbol_out || m_tuser !== r.status || m_tlast !== r.last) begin
						fail_tally++;
						$display("%0t: result mismatch: expected sym %h st %0d last %b, got sym %h st %0d last %b",
							$time, r.symbol_out, r.status, r.last, m_tdata, m_tuser, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == CMD_LOAD) begin
					r.symbol_out = '0;
					r.status     = insert_code(s_tdata[SYM_W-1:0],
						s_tdata[LEN_LSB-1:CODE_LSB], s_tdata[BYTE_LSB-1:LEN_LSB]);
					r.last       = 1'b1;
					awaited_results.push_back(r);
				end else begin
					decode_byte(s_tdata[SKIP_LSB-1:BYTE_LSB], s_tdata[SKIP_LSB+SKIP_W-1:SKIP_LSB]);
				end
			end
			pending    <= awaited_results.size();
			table_full <= (nodes_used >= NODES);
		end
	end

endmodule

>>> tb/tb_top.sv
// Top of the code-tree walk decoder regression: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
	import hftd_pkg::*;

	// no request moves on either channel for this long -> hung
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int RANDOM_ITEMS   = 90;
	localparam int FILL_MAX       = 40;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [1:0]           m_tuser;
	logic                 m_tlast;

	int   errors;
	int   pending;
	logic table_full;
	int   results_seen;
	int   bad_paths;
	int   full_loads;

	// set for the closing phases: no gaps on either side
	bit   calm;
	int   load_reqs;
	int   decode_reqs;
	int   idle_cycles;

	huffman_tree_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	hftd_scoreboard u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.errors       (errors),
		.pending      (pending),
		.table_full   (table_full),
		.results_seen (results_seen),
		.bad_paths    (bad_paths),
		.full_loads   (full_loads)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog: counts edges with no request moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d results still owed", $time, pending);
			$display("huffman_tree_decoder regression: fail");
			$finish;
		end
	end

	// result side: ready runs of random length, each followed half the time by a stall burst;
	// some runs are long so stretches without back-pressure occur too
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			m_tready <= 1'b1;
			if (calm)
				@(posedge clk);
			else begin
				repeat (($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12))
					@(posedge clk);
				if (!calm && $urandom_range(0, 1) == 1) begin
					m_tready <= 1'b0;
					repeat ($urandom_range(1, 13)) @(posedge clk);
				end
			end
		end
	end

	// One request on the slave side; returns at the edge where it was taken.
	// An optional gap goes in front of it.
	task automatic send_request(input logic cmd, input logic [SYM_W-1:0] sym,
			input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
			input logic [BYTE_W-1:0] coded, input logic [SKIP_W-1:0] skip);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'd0, skip, coded, len, code, sym};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_DECODE)
			decode_reqs++;
		else
			load_reqs++;
	endtask

	// unused fields of each request kind carry noise so every bit toggles
	task automatic load_code(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] code,
			input logic [LEN_W-1:0] len);
		send_request(CMD_LOAD, sym, code, len, BYTE_W'($urandom), SKIP_W'($urandom));
	endtask

	task automatic decode_bits(input logic [BYTE_W-1:0] coded, input logic [SKIP_W-1:0] skip);
		send_request(CMD_DECODE, SYM_W'($urandom), $urandom, LEN_W'($urandom), coded, skip);
	endtask

	// mostly short codes so decodes land on leaves; now and then symbol 0
	// (turns a leaf back into a pass-through node) or any length up to 63
	task automatic random_load(input bit full_length);
		logic [SYM_W-1:0] sym;
		logic [LEN_W-1:0] len;
		sym = ($urandom_range(0, 7) == 0) ? '0 : SYM_W'($urandom_range(1, 255));
		if (full_length)
			len = LEN_W'(MAX_CODE_LEN_DEF);
		else if ($urandom_range(0, 9) == 0)
			len = LEN_W'($urandom_range(0, 63));
		else
			len = LEN_W'($urandom_range(1, 9));
		load_code(sym, $urandom, len);
	endtask

	task automatic random_decode();
		decode_bits(BYTE_W'($urandom), ($urandom_range(0, 2) == 0) ? SKIP_W'($urandom) : '0);
	endtask

	initial begin
		int fill_loads;
		arst_n      <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		s_tuser     <= 1'b0;
		calm        = 1'b0;
		load_reqs   = 0;
		decode_reqs = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// empty tree: every bit misses at the root, eight results, then a one-bit byte
		decode_bits(8'h00, 3'd0);
		decode_bits(8'hFF, 3'd7);
		// zero-length load changes nothing
		load_code(8'h55, 32'hFFFF_FFFF, 6'd0);
		// symbol 0 on code 01 leaves both nodes internal
		load_code(8'h00, 32'h1, 6'd2);
		// prefix code A=0 B=10 C=110 D=111; A now also has a child
		load_code(8'h41, 32'h0, 6'd1);
		load_code(8'h42, 32'h2, 6'd2);
		load_code(8'h43, 32'h6, 6'd3);
		load_code(8'hFF, 32'h7, 6'd3);
		// A B C then a half code that carries over into the next byte
		decode_bits(8'h5B, 3'd0);
		decode_bits(8'h80, 3'd7);
		// two bits only, no result
		decode_bits(8'hC0, 3'd6);
		// a load in the middle of a walk must not disturb it
		load_code(8'h80, 32'hD, 6'd4);
		decode_bits(8'h3C, 3'd0);
		// over-long codes clip to the maximum, running through existing leaves
		load_code(8'h01, 32'hFFFF_FFFF, 6'd63);
		load_code(8'h7F, 32'h0000_0000, 6'd32);
		load_code(8'h99, 32'hAAAA_AAAA, 6'd33);
		decode_bits(8'hFF, 3'd0);
		// eight leaves from one byte
		decode_bits(8'h00, 3'd0);
		// clear B so the walk goes on below it and misses mid-byte
		load_code(8'h00, 32'h2, 6'd2);
		decode_bits(8'h80, 3'd0);

		repeat (RANDOM_ITEMS) begin
			if ($urandom_range(0, 99) < 35)
				random_load(1'b0);
			else
				random_decode();
		end

		// closing phases run without gaps: fill the node table with full-length codes
		calm = 1'b1;
		fill_loads = 0;
		while (!table_full && fill_loads < FILL_MAX) begin
			random_load(1'b1);
			fill_loads++;
		end
		// existing path still loads, new paths report the table full
		load_code(8'h33, 32'h0, 6'd1);
		repeat (3) random_load(1'b1);
		repeat (20) random_decode();

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d load and %0d decode requests, %0d results checked",
			load_reqs, decode_reqs, results_seen);
		$display("of those %0d invalid-path results and %0d table-full loads; table full: %b",
			bad_paths, full_loads, table_full);
		if (errors == 0)
			$display("huffman_tree_decoder regression: pass");
		else
			$display("huffman_tree_decoder regression: fail");
		$finish;
	end

endmodule
